// ----- rtl/orpt_pkg.sv -----
// ---------------------------------------------------------------------------
// Oriented rectangle point test package
// Shared types, register indexes and the CORDIC angle table.
// ---------------------------------------------------------------------------
`default_nettype none

package orpt_pkg;

  localparam int CfgAddrW = 3;

  typedef enum logic [CfgAddrW-1:0] {
    REG_START_X     = 3'd0,
    REG_START_Y     = 3'd1,
    REG_HEADING     = 3'd2,
    REG_RECT_WIDTH  = 3'd3,
    REG_RECT_HEIGHT = 3'd4
  } cfg_reg_e;

  localparam int HdgW  = 16;
  localparam int TrigW = 16;
  localparam int MagW  = 31;
  localparam int CrdW  = 34;
  localparam logic signed [CrdW-1:0] CordicGain = 34'sd652032874;

  typedef struct packed {
    logic                    valid;
    logic signed [TrigW-1:0] cos_v;
    logic signed [TrigW-1:0] sin_v;
    logic        [MagW-1:0]  mag;
  } trig_t;

  function automatic logic [31:0] atan_lut(input logic [3:0] idx);
    logic [31:0] v;
    unique case (idx)
      4'd0:  v = 32'd536870912;
      4'd1:  v = 32'd316933406;
      4'd2:  v = 32'd167458907;
      4'd3:  v = 32'd85004756;
      4'd4:  v = 32'd42667331;
      4'd5:  v = 32'd21354465;
      4'd6:  v = 32'd10679838;
      4'd7:  v = 32'd5340245;
      4'd8:  v = 32'd2670163;
      4'd9:  v = 32'd1335087;
      4'd10: v = 32'd667544;
      4'd11: v = 32'd333772;
      4'd12: v = 32'd166886;
      4'd13: v = 32'd83443;
      4'd14: v = 32'd41722;
      4'd15: v = 32'd20861;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/orpt_cordic.sv -----
// ---------------------------------------------------------------------------
// Heading to unit vector
// Iterative CORDIC, one rotation per cycle, then rounding, quadrant fold and
// the squared magnitude of the Q1.15 vector.
// ---------------------------------------------------------------------------
`default_nettype none

module orpt_cordic (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       hdg_we_i,
  input  wire logic [orpt_pkg::HdgW-1:0]  hdg_i,
  output orpt_pkg::trig_t                 trig_o
);

  typedef enum logic [5:0] {
    C_LOAD  = 6'b000001,
    C_ITER  = 6'b000010,
    C_ROUND = 6'b000100,
    C_SQC   = 6'b001000,
    C_SQS   = 6'b010000,
    C_DONE  = 6'b100000
  } cstate_e;

  localparam int W = orpt_pkg::CrdW;
  localparam int T = orpt_pkg::TrigW;

  cstate_e st_q, st_d;
  logic [orpt_pkg::HdgW-1:0] hdg_q;
  logic [3:0] i_q, i_d;
  logic [1:0] quad_q, quad_d;
  logic signed [W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [T-1:0] cos_q, cos_d, sin_q, sin_d;
  logic [31:0] sq_q, sq_d;
  logic [orpt_pkg::MagW-1:0] mag_q, mag_d;

  logic [15:0] hsum, rem;
  logic signed [W-1:0] at, dx, dy, xr, yr;
  logic signed [T-1:0] cr, sr;
  logic signed [31:0] prod;

  always_comb begin
    hsum = hdg_q + 16'h2000;
    rem  = hdg_q - {hsum[15:14], 14'd0};
    at   = $signed({2'b00, orpt_pkg::atan_lut(i_q)});
    dx   = y_q >>> i_q;
    dy   = x_q >>> i_q;
    xr   = (x_q + 34'sd16384) >>> 15;
    yr   = (y_q + 34'sd16384) >>> 15;
    if (xr > 34'sd32767) begin
      cr = 16'sd32767;
    end else if (xr < -34'sd32767) begin
      cr = -16'sd32767;
    end else begin
      cr = xr[T-1:0];
    end
    if (yr > 34'sd32767) begin
      sr = 16'sd32767;
    end else if (yr < -34'sd32767) begin
      sr = -16'sd32767;
    end else begin
      sr = yr[T-1:0];
    end
    prod = (st_q == C_SQC) ? (cos_q * cos_q) : (sin_q * sin_q);
  end

  always_comb begin
    st_d   = st_q;
    i_d    = i_q;
    quad_d = quad_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cos_d  = cos_q;
    sin_d  = sin_q;
    sq_d   = sq_q;
    mag_d  = mag_q;
    unique case (st_q)
      C_LOAD: begin
        quad_d = hsum[15:14];
        x_d    = orpt_pkg::CordicGain;
        y_d    = '0;
        z_d    = $signed({{2{rem[15]}}, rem, 16'd0});
        i_d    = '0;
        st_d   = C_ITER;
      end
      C_ITER: begin
        if (!z_q[W-1]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - at;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + at;
        end
        i_d = i_q + 4'd1;
        if (i_q == 4'd15) begin
          st_d = C_ROUND;
        end
      end
      C_ROUND: begin
        unique case (quad_q)
          2'd0: begin cos_d = cr;  sin_d = sr;  end
          2'd1: begin cos_d = -sr; sin_d = cr;  end
          2'd2: begin cos_d = -cr; sin_d = -sr; end
          default: begin cos_d = sr; sin_d = -cr; end
        endcase
        st_d = C_SQC;
      end
      C_SQC: begin
        sq_d = prod;
        st_d = C_SQS;
      end
      C_SQS: begin
        mag_d = sq_q[orpt_pkg::MagW-1:0] + prod[orpt_pkg::MagW-1:0];
        st_d  = C_DONE;
      end
      C_DONE: begin
        st_d = C_DONE;
      end
      default: st_d = C_LOAD;
    endcase
    if (hdg_we_i) begin
      st_d = C_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= C_LOAD;
      hdg_q <= '0;
    end else begin
      st_q <= st_d;
      if (hdg_we_i) begin
        hdg_q <= hdg_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    quad_q <= quad_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    cos_q  <= cos_d;
    sin_q  <= sin_d;
    sq_q   <= sq_d;
    mag_q  <= mag_d;
  end

  assign trig_o.valid = (st_q == C_DONE);
  assign trig_o.cos_v = cos_q;
  assign trig_o.sin_v = sin_q;
  assign trig_o.mag   = mag_q;

endmodule

`default_nettype wire

// ----- rtl/orpt_front.sv -----
// ---------------------------------------------------------------------------
// Request front end
// Accepts requests, splits the action from the operands and holds them in a
// two-entry queue for the execution unit.
// ---------------------------------------------------------------------------
`default_nettype none

module orpt_front #(
  parameter int CoordBits = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 in_action_i,
  input  wire logic [CoordBits-1:0] in_px_i,
  input  wire logic [CoordBits-1:0] in_py_i,
  input  wire logic [CoordBits-1:0] in_dist_i,
  output logic                      item_valid_o,
  input  wire logic                 item_pop_i,
  output logic                      item_action_o,
  output logic [CoordBits-1:0]      item_px_o,
  output logic [CoordBits-1:0]      item_py_o,
  output logic [CoordBits-1:0]      item_dist_o
);

  localparam int EW = 1 + 3 * CoordBits;

  logic [EW-1:0] ent_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push;
  logic [EW-1:0] head;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign head         = ent_q[rd_ptr_q];

  assign item_action_o = head[0];
  assign item_px_o     = head[CoordBits:1];
  assign item_py_o     = head[2*CoordBits:CoordBits+1];
  assign item_dist_o   = head[3*CoordBits:2*CoordBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (item_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, item_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= {in_dist_i, in_py_i, in_px_i, in_action_i};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/orpt_back.sv -----
// ---------------------------------------------------------------------------
// Execution unit
// Runs one request at a time through a shared multiplier: dot products and
// slab bounds for a point test, the forward step for a move. Holds the
// center, the side lengths and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module orpt_back #(
  parameter int CoordBits = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             item_valid_i,
  output logic                                  item_pop_o,
  input  wire logic                             item_action_i,
  input  wire logic [CoordBits-1:0]             item_px_i,
  input  wire logic [CoordBits-1:0]             item_py_i,
  input  wire logic [CoordBits-1:0]             item_dist_i,
  input  orpt_pkg::trig_t                       trig_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [orpt_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  wire logic [CoordBits-1:0]             cfg_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  out_inside_o,
  output logic [CoordBits-1:0]                  out_cx_o,
  output logic [CoordBits-1:0]                  out_cy_o
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_MUL  = 3'b010,
    B_FIN  = 3'b100
  } bstate_e;

  localparam int AW = CoordBits + 1;
  localparam int BW = 17;
  localparam int PW = AW + BW;
  localparam int GW = PW + 1;
  localparam logic signed [GW-1:0] Rnd  = GW'(16384);
  localparam logic signed [GW-1:0] CMax = (GW'(1) <<< (CoordBits - 1)) - GW'(1);
  localparam logic signed [GW-1:0] CMin = -CMax - GW'(1);

  bstate_e st_q;
  logic [3:0] step_q;
  logic       act_q;
  logic signed [AW-1:0] dx_q, dy_q;
  logic signed [PW-1:0] prod_q;
  logic signed [GW-1:0] g_q, h_q, bw_q, bh_q;
  logic [CoordBits-1:0] cx_q, cy_q;
  logic [CoordBits-2:0] w_q, h_len_q;
  logic out_valid_q, out_inside_q;
  logic [CoordBits-1:0] out_cx_q, out_cy_q;

  logic signed [AW-1:0] opa, w_ext, hl_ext;
  logic signed [BW-1:0] opb, c_ext, s_ext, mlo, mhi;
  logic signed [PW-1:0] prod_d;
  logic signed [GW-1:0] prod_x, nx, ny;
  logic signed [GW:0]   gx, hx, bwx, bhx;
  logic ok_w, ok_h, in_rect, take, last;
  logic [CoordBits-1:0] new_cx, new_cy;

  assign w_ext  = $signed({2'b00, w_q});
  assign hl_ext = $signed({2'b00, h_len_q});
  assign c_ext  = $signed({trig_i.cos_v[orpt_pkg::TrigW-1], trig_i.cos_v});
  assign s_ext  = $signed({trig_i.sin_v[orpt_pkg::TrigW-1], trig_i.sin_v});
  assign mlo    = $signed({1'b0, trig_i.mag[15:0]});
  assign mhi    = $signed({2'b00, trig_i.mag[orpt_pkg::MagW-1:16]});

  always_comb begin
    opa = dx_q;
    opb = c_ext;
    if (act_q) begin
      opb = (step_q == 4'd0) ? c_ext : s_ext;
    end else begin
      unique case (step_q)
        4'd0: begin opa = dx_q;   opb = s_ext; end
        4'd1: begin opa = dy_q;   opb = c_ext; end
        4'd2: begin opa = dx_q;   opb = c_ext; end
        4'd3: begin opa = dy_q;   opb = s_ext; end
        4'd4: begin opa = w_ext;  opb = mlo;   end
        4'd5: begin opa = w_ext;  opb = mhi;   end
        4'd6: begin opa = hl_ext; opb = mlo;   end
        4'd7: begin opa = hl_ext; opb = mhi;   end
        default: begin opa = dx_q; opb = c_ext; end
      endcase
    end
    prod_d = opa * opb;
  end

  assign prod_x = {prod_q[PW-1], prod_q};
  assign last   = act_q ? (step_q == 4'd2) : (step_q == 4'd8);

  always_comb begin
    gx      = {g_q[GW-1], g_q};
    hx      = {h_q[GW-1], h_q};
    bwx     = {bw_q[GW-1], bw_q};
    bhx     = {bh_q[GW-1], bh_q};
    ok_w    = (w_q == '0) || ((gx <= bwx) && (-gx <= bwx));
    ok_h    = (h_len_q == '0) || ((hx <= bhx) && (-hx <= bhx));
    in_rect = ok_w && ok_h;
    nx = $signed({{(GW-CoordBits){cx_q[CoordBits-1]}}, cx_q}) + ((g_q + Rnd) >>> 15);
    ny = $signed({{(GW-CoordBits){cy_q[CoordBits-1]}}, cy_q}) + ((h_q + Rnd) >>> 15);
    if (nx > CMax) begin
      new_cx = CMax[CoordBits-1:0];
    end else if (nx < CMin) begin
      new_cx = CMin[CoordBits-1:0];
    end else begin
      new_cx = nx[CoordBits-1:0];
    end
    if (ny > CMax) begin
      new_cy = CMax[CoordBits-1:0];
    end else if (ny < CMin) begin
      new_cy = CMin[CoordBits-1:0];
    end else begin
      new_cy = ny[CoordBits-1:0];
    end
  end

  assign item_pop_o = (st_q == B_IDLE) && item_valid_i && trig_i.valid;
  assign take       = (st_q == B_FIN) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      w_q         <= '0;
      h_len_q     <= '0;
    end else begin
      unique case (st_q)
        B_IDLE: begin
          if (item_pop_o) begin
            step_q <= '0;
            st_q   <= B_MUL;
          end
        end
        B_MUL: begin
          step_q <= step_q + 4'd1;
          if (last) begin
            st_q <= B_FIN;
          end
        end
        B_FIN: begin
          if (take) begin
            st_q <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
      if (take) begin
        out_valid_q <= 1'b1;
        if (act_q) begin
          cx_q <= new_cx;
          cy_q <= new_cy;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          orpt_pkg::REG_START_X:     cx_q    <= cfg_data_i;
          orpt_pkg::REG_START_Y:     cy_q    <= cfg_data_i;
          orpt_pkg::REG_RECT_WIDTH:  w_q     <= cfg_data_i[CoordBits-2:0];
          orpt_pkg::REG_RECT_HEIGHT: h_len_q <= cfg_data_i[CoordBits-2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      act_q <= item_action_i;
      if (item_action_i) begin
        dx_q <= $signed({item_dist_i[CoordBits-1], item_dist_i});
      end else begin
        dx_q <= $signed({item_px_i[CoordBits-1], item_px_i})
              - $signed({cx_q[CoordBits-1], cx_q});
      end
      dy_q <= $signed({item_py_i[CoordBits-1], item_py_i})
            - $signed({cy_q[CoordBits-1], cy_q});
    end
    if (st_q == B_MUL) begin
      prod_q <= prod_d;
      if (act_q) begin
        unique case (step_q)
          4'd1: g_q <= prod_x;
          4'd2: h_q <= prod_x;
          default: ;
        endcase
      end else begin
        unique case (step_q)
          4'd1: g_q  <= -prod_x;
          4'd2: g_q  <= g_q + prod_x;
          4'd3: h_q  <= prod_x;
          4'd4: h_q  <= h_q + prod_x;
          4'd5: bw_q <= prod_x >>> 16;
          4'd6: bw_q <= bw_q + prod_x;
          4'd7: bh_q <= prod_x >>> 16;
          4'd8: bh_q <= bh_q + prod_x;
          default: ;
        endcase
      end
    end
    if (take) begin
      out_inside_q <= act_q ? 1'b0 : in_rect;
      out_cx_q     <= act_q ? new_cx : cx_q;
      out_cy_q     <= act_q ? new_cy : cy_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_inside_o = out_inside_q;
  assign out_cx_o     = out_cx_q;
  assign out_cy_o     = out_cy_q;

endmodule

`default_nettype wire

// ----- rtl/oriented_rect_point_test.sv -----
// ---------------------------------------------------------------------------
// Oriented rectangle point test
// Point containment and forward moves for a rectangle with a stored center.
// ---------------------------------------------------------------------------
// The shared multiplier runs eight products per test and two per move; the execution
// unit finishes one request before it takes the next, and new requests queue meanwhile.
// Reset and heading writes start a CORDIC pass; requests queue meanwhile.
// Reset clears the center, the heading and both side lengths.
`default_nettype none

module oriented_rect_point_test #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // point_x, point_y, distance
  input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // action
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // inside_res, center_x, center_y
  output logic [((2*COORD_BITS+8)/8)*8-1:0]        m_axis_tdata,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [orpt_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  wire logic [COORD_BITS-1:0]               cfg_data_i
);

  localparam int OutW = ((2*COORD_BITS+8)/8)*8;

  logic item_valid, item_pop, item_action, cfg_we;
  logic [COORD_BITS-1:0] item_px, item_py, item_dist, out_cx, out_cy;
  logic out_inside;
  orpt_pkg::trig_t trig;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  orpt_front #(.CoordBits(COORD_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_action_i   (s_axis_tuser),
    .in_px_i       (s_axis_tdata[COORD_BITS-1:0]),
    .in_py_i       (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_dist_i     (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .item_valid_o  (item_valid),
    .item_pop_i    (item_pop),
    .item_action_o (item_action),
    .item_px_o     (item_px),
    .item_py_o     (item_py),
    .item_dist_o   (item_dist)
  );

  orpt_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .hdg_we_i (cfg_we && (cfg_addr_i == orpt_pkg::REG_HEADING)),
    .hdg_i    (cfg_data_i[orpt_pkg::HdgW-1:0]),
    .trig_o   (trig)
  );

  orpt_back #(.CoordBits(COORD_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_pop_o    (item_pop),
    .item_action_i (item_action),
    .item_px_i     (item_px),
    .item_py_i     (item_py),
    .item_dist_i   (item_dist),
    .trig_i        (trig),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_inside_o  (out_inside),
    .out_cx_o      (out_cx),
    .out_cy_o      (out_cy)
  );

  assign m_axis_tdata = OutW'({out_cy, out_cx, out_inside});

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid)
    else $error("request popped from an empty queue");

  a_pop_needs_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> trig.valid)
    else $error("request started before the unit vector was ready");

  a_heading_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we && (cfg_addr_i == orpt_pkg::REG_HEADING)) |=> !trig.valid)
    else $error("heading write did not restart the unit vector");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ---------------------------------------------------------------------------
// Oriented rectangle point test bench
// Drives test and move requests through the stream ports and reprograms the
// rectangle between phases. A cycle-free model of the heading rotation, the
// containment test and the saturating move predicts each result but those of
// fixed table rows; results are compared field by field in order of arrival.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int          IdleLimit = 4000;
  localparam logic        ACT_TEST  = 1'b0;
  localparam logic        ACT_MOVE  = 1'b1;
  localparam logic [2:0]  REG_SPARE_5 = 3'd5;
  localparam logic [2:0]  REG_SPARE_7 = 3'd7;
  localparam longint      CoordMax = 64'sd2147483647;
  localparam longint      CoordMin = -64'sd2147483648;
  localparam longint      AtanTab[16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  addr;
    logic        act;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] mv;
    logic        fixed;
    logic        e_inside;
    logic [31:0] e_cx;
    logic [31:0] e_cy;
  } row_t;

  typedef struct {
    logic        in_rect;
    logic [31:0] cx;
    logic [31:0] cy;
  } rect_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_addr_i = '0;
  logic [31:0] cfg_data_i = '0;

  rect_result_t pending_q[$];
  longint       ctr_x, ctr_y, rect_w, rect_h;
  logic [15:0]  hdg;
  int           errors = 0;
  int           idle_cycles = 0;
  int           burst_left = 0;
  int           rdy_mode = 0;
  int           rdy_cnt = 0;
  row_t         dir_tab[];

  oriented_rect_point_test uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  function automatic longint clamp_q15(input longint v);
    return v > 32767 ? 32767 : (v < -32767 ? -32767 : v);
  endfunction

  function automatic longint sat_coord(input longint v);
    return v > CoordMax ? CoordMax : (v < CoordMin ? CoordMin : v);
  endfunction

  function automatic longint slab_limit(input longint len, input longint m);
    return (len >>> 16) * m + (((len & 64'hFFFF) * m) >>> 16);
  endfunction

  function automatic void heading_vec(input logic [15:0] hd, output longint cv,
                                      output longint sv);
    int unsigned quad;
    logic [15:0] rem;
    longint      z, x, y, dx, dy, c, s;
    quad = ((int'(hd) + 32'h2000) >> 14) & 3;
    rem  = hd - 16'(quad * 16384);
    z    = longint'($signed(rem)) * 65536;
    x    = 652032874;
    y    = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    c = clamp_q15((x + 16384) >>> 15);
    s = clamp_q15((y + 16384) >>> 15);
    case (quad)
      0: begin cv = c;  sv = s;  end
      1: begin cv = -s; sv = c;  end
      2: begin cv = -c; sv = -s; end
      default: begin cv = s; sv = -c; end
    endcase
  endfunction

  function automatic rect_result_t predict_rect(input logic act, input logic [31:0] px,
                                                input logic [31:0] py,
                                                input logic [31:0] mv);
    rect_result_t r;
    longint c, s, dx, dy, m, g, h;
    logic ok_w, ok_h;
    heading_vec(hdg, c, s);
    r.in_rect = 1'b0;
    if (act == ACT_TEST) begin
      dx = longint'($signed(px)) - ctr_x;
      dy = longint'($signed(py)) - ctr_y;
      m  = c * c + s * s;
      g  = dx * (-s) + dy * c;
      h  = dx * c + dy * s;
      if (g < 0) g = -g;
      if (h < 0) h = -h;
      ok_w = (rect_w == 0) || (g <= slab_limit(rect_w, m));
      ok_h = (rect_h == 0) || (h <= slab_limit(rect_h, m));
      r.in_rect = ok_w && ok_h;
    end else begin
      ctr_x = sat_coord(ctr_x + ((longint'($signed(mv)) * c + 16384) >>> 15));
      ctr_y = sat_coord(ctr_y + ((longint'($signed(mv)) * s + 16384) >>> 15));
    end
    r.cx = ctr_x[31:0];
    r.cy = ctr_y[31:0];
    return r;
  endfunction

  task automatic send_req(input logic act, input logic [31:0] px, input logic [31:0] py,
                          input logic [31:0] mv, input logic fixed,
                          input rect_result_t fixed_res);
    rect_result_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {mv, py, px};
    cfg_valid_i   <= 1'b0;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_rect(act, px, py, mv);
    pending_q.push_back(fixed ? fixed_res : r);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 250 : $urandom_range(1, 30);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (addr)
      orpt_pkg::REG_START_X:     ctr_x = longint'($signed(data));
      orpt_pkg::REG_START_Y:     ctr_y = longint'($signed(data));
      orpt_pkg::REG_HEADING:     hdg = data[15:0];
      orpt_pkg::REG_RECT_WIDTH:  rect_w = longint'(data[30:0]);
      orpt_pkg::REG_RECT_HEIGHT: rect_h = longint'(data[30:0]);
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_side();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return {$urandom_range(0, 1) == 1, 31'h7FFF_FFFF};
      default: return $urandom >> $urandom_range(4, 31);
    endcase
  endfunction

  function automatic logic [31:0] pick_start();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return $signed($urandom) >>> $urandom_range(4, 31);
    endcase
  endfunction

  function automatic logic [15:0] pick_heading();
    logic [15:0] corners[8] = '{16'h0000, 16'hFFFF, 16'h2000, 16'h1FFF,
                                16'h4000, 16'h8000, 16'hC000, 16'h6000};
    return ($urandom_range(0, 2) == 0) ? corners[$urandom_range(0, 7)]
                                       : 16'($urandom);
  endfunction

  always @(posedge clk_i) begin
    if (rdy_cnt == 0) begin
      rdy_mode <= $urandom_range(0, 2);
      rdy_cnt  <= $urandom_range(50, 300);
    end else begin
      rdy_cnt <= rdy_cnt - 1;
    end
    case (rdy_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 3) != 0;
      default: m_axis_tready <= $urandom_range(0, 3) == 0;
    endcase
  end

  always @(posedge clk_i) begin
    rect_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tdata[0] !== e.in_rect) begin
          $error("inside_res: expected %0d, got %0d", e.in_rect, m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tdata[32:1] !== e.cx) begin
          $error("center_x: expected %h, got %h", e.cx, m_axis_tdata[32:1]);
          errors++;
        end
        if (m_axis_tdata[64:33] !== e.cy) begin
          $error("center_y: expected %h, got %h", e.cy, m_axis_tdata[64:33]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rect_result_t fx;
    logic         act;
    logic [31:0]  px, py, mv_len, off;
    ctr_x = 0; ctr_y = 0; rect_w = 0; rect_h = 0; hdg = '0;
    dir_tab = '{
      '{ROW_ITEM, 3'd0, ACT_TEST, 32'h0, 32'h0, 32'h0, 1, 1, 32'h0, 32'h0},
      '{ROW_ITEM, 3'd0, ACT_TEST, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1, 1, 32'h0, 32'h0},
      '{ROW_ITEM, 3'd0, ACT_TEST, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1, 1, 32'h0, 32'h0},
      '{ROW_ITEM, 3'd0, ACT_TEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1, 1, 32'h0, 32'h0},
      '{ROW_CFG, orpt_pkg::REG_RECT_WIDTH, 0, 32'h0002_0000, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, orpt_pkg::REG_RECT_HEIGHT, 0, 32'h0004_0000, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_TEST, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_TEST, 32'h0002_0000, 32'h0001_0000, 32'h0, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_TEST, 32'h0002_0001, 32'h0, 32'h0, 0, 0, 0, 0},
      '{ROW_CFG, orpt_pkg::REG_HEADING, 0, 32'h0000_4000, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_MOVE, 32'h0, 32'h0, 32'h0001_0000, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_TEST, 32'h0001_0000, 32'h0001_0000, 32'h0, 0, 0, 0, 0},
      '{ROW_CFG, orpt_pkg::REG_HEADING, 0, 32'hABCD_FFFF, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_MOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0, 0, 0},
      '{ROW_CFG, orpt_pkg::REG_START_X, 0, 32'h7FFF_0000, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, orpt_pkg::REG_START_Y, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_MOVE, 32'h0, 32'h0, 32'h7FFF_FFFF, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_MOVE, 32'h0, 32'h0, 32'h8000_0000, 0, 0, 0, 0},
      '{ROW_CFG, orpt_pkg::REG_HEADING, 0, 32'h0000_2000, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_MOVE, 32'h0, 32'h0, 32'h0010_0000, 0, 0, 0, 0},
      '{ROW_CFG, orpt_pkg::REG_HEADING, 0, 32'h0000_6000, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, orpt_pkg::REG_RECT_WIDTH, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, orpt_pkg::REG_RECT_HEIGHT, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_TEST, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_TEST, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 0, 0, 0, 0},
      '{ROW_CFG, REG_SPARE_5, 0, 32'h1234_5678, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, REG_SPARE_7, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_TEST, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0},
      '{ROW_CFG, orpt_pkg::REG_RECT_WIDTH, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, orpt_pkg::REG_HEADING, 0, 32'h0000_C000, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_TEST, 32'h1234_5678, 32'h8000_0001, 32'h0, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_MOVE, 32'h0, 32'h0, 32'hFFFF_FFFF, 0, 0, 0, 0},
      '{ROW_CFG, orpt_pkg::REG_RECT_HEIGHT, 0, 32'h0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 3'd0, ACT_TEST, 32'h0, 32'h7FFF_0000, 32'h0, 0, 0, 0, 0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_tab[i].addr, dir_tab[i].a);
      end else begin
        fx = '{dir_tab[i].e_inside, dir_tab[i].e_cx, dir_tab[i].e_cy};
        send_req(dir_tab[i].act, dir_tab[i].a, dir_tab[i].b, dir_tab[i].mv,
                 dir_tab[i].fixed, fx);
        pace();
      end
    end

    for (int ph = 0; ph < 11; ph++) begin
      drain();
      write_reg(orpt_pkg::REG_HEADING, {16'($urandom), pick_heading()});
      write_reg(orpt_pkg::REG_RECT_WIDTH, pick_side());
      write_reg(orpt_pkg::REG_RECT_HEIGHT, pick_side());
      write_reg(orpt_pkg::REG_START_X, pick_start());
      write_reg(orpt_pkg::REG_START_Y, pick_start());
      for (int n = 0; n < 100; n++) begin
        act    = ($urandom_range(0, 9) < 3) ? ACT_MOVE : ACT_TEST;
        px     = $urandom;
        py     = $urandom;
        mv_len = ($urandom_range(0, 3) == 0) ? $urandom
                                             : $signed($urandom) >>> $urandom_range(0, 31);
        if ($urandom_range(0, 3) != 0) begin
          off = $signed($urandom) >>> $urandom_range(0, 31);
          px  = ctr_x[31:0] + off;
          off = $signed($urandom) >>> $urandom_range(0, 31);
          py  = ctr_y[31:0] + off;
        end
        send_req(act, px, py, mv_len, 1'b0, fx);
        pace();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- oriented_rect_point_test.f -----
rtl/orpt_pkg.sv
rtl/orpt_cordic.sv
rtl/orpt_front.sv
rtl/orpt_back.sv
rtl/oriented_rect_point_test.sv
dv/tb_top.sv
